FILE: hdl/dnsrp_pkg.sv
// shared types and constants for the dns response record parser
// no dependencies

package dnsrp_pkg;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_RCODE  = 3'd1,
        KIND_SHORT  = 3'd2,
        KIND_A      = 3'd3,
        KIND_AAAA   = 3'd4,
        KIND_OTHER  = 3'd5,
        KIND_END    = 3'd6
    } kind_t;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_NAME   = 8'b0000_0010,
        PH_LABEL  = 8'b0000_0100,
        PH_FIXED  = 8'b0000_1000,
        PH_SKIP   = 8'b0001_0000,
        PH_ADDR   = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_PTR    = 8'b1000_0000
    } phase_t;

    localparam logic [3:0]  HDR_LAST    = 4'd11;
    localparam logic [3:0]  QFIXED_LAST = 4'd3;
    localparam logic [3:0]  RFIXED_LAST = 4'd9;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] TYPE_AAAA   = 16'd28;
    localparam logic [15:0] LEN_A       = 16'd4;
    localparam logic [15:0] LEN_AAAA    = 16'd16;
    localparam logic [7:0]  PTR_MASK    = 8'hc0;

    // one result transaction
    typedef struct packed {
        kind_t        kind;
        logic         message_end;
        logic [15:0]  txid;
        logic [15:0]  flags;
        logic [15:0]  question_count;
        logic [15:0]  answer_count;
        logic [15:0]  record_type;
        logic [31:0]  time_to_live;
        logic [15:0]  data_length;
        logic [63:0]  address_high;
        logic [63:0]  address_low;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: hdl/dns_response_record_parser_top.sv
// DNS response record parser: one message byte per transaction in,
// one decoded header, answer record or end mark per transaction out.
// Channels: s_axis_* carries a byte (tdata) and end-of-message mark (tlast).
// m_axis_* carries result transactions; message_end travels as tlast,
// the other fields are packed in tdata.
// Throughput: one byte per cycle while the result queue has room; a
// byte gives at most one result, written into the result queue when the
// byte that causes it is accepted, and read out on m_axis from there.
// The byte parser runs every cycle that a byte is accepted; the only stall
// comes from the result queue: s_axis_tready drops when it is full, so
// a stalled receiver holds the input after DEPTH results are waiting.
// Reset: the parser returns to the header phase and the queue empties.
// A final byte always yields a result and resets the parser for the next
// message.
// depends on dnsrp_pkg, dnsrp_front, dnsrp_queue

module dns_response_record_parser_top import dnsrp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[2:0], txid, flags, question_count, answer_count, record_type,
    // time_to_live, data_length, address_high, address_low; zero pad to 264
    output logic [263:0] m_axis_tdata,
    output logic         m_axis_tlast    // message_end
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t q_out;
    logic    q_ready;

    assign accept        = s_axis_tvalid && q_ready;
    assign s_axis_tready = q_ready;

    // byte parser
    dnsrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // result queue
    dnsrp_queue #(.DEPTH(DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_ready (q_ready),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (q_out)
    );

    // output packing
    assign m_axis_tlast = q_out.message_end;
    assign m_axis_tdata = {
        5'd0,
        q_out.address_low,
        q_out.address_high,
        q_out.data_length,
        q_out.time_to_live,
        q_out.record_type,
        q_out.answer_count,
        q_out.question_count,
        q_out.flags,
        q_out.txid,
        q_out.kind
    };

endmodule

FILE: hdl/dnsrp_front.sv
// front part: byte parser state machine, emits at most one result per byte
// depends on dnsrp_pkg

module dnsrp_front import dnsrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t       phase_reg, phase_next;
    logic [3:0]   idx_reg, idx_next;
    logic [63:0]  hdr_reg, hdr_next;
    logic [15:0]  q_reg, q_next;
    logic [15:0]  a_reg, a_next;
    logic [7:0]   lab_reg, lab_next;
    logic [63:0]  fix_reg, fix_next;
    logic [15:0]  rd_reg, rd_next;
    logic [63:0]  ah_reg, ah_next;
    logic [63:0]  al_reg, al_next;

    logic [63:0]  hdr_new;
    logic [63:0]  fix_new;
    logic [15:0]  rd_new;
    logic [15:0]  a_dec;
    logic [15:0]  rtype;
    logic [63:0]  al_new;
    logic [63:0]  ah_new;

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        hdr_next   = hdr_reg;
        q_next     = q_reg;
        a_next     = a_reg;
        lab_next   = lab_reg;
        fix_next   = fix_reg;
        rd_next    = rd_reg;
        ah_next    = ah_reg;
        al_next    = al_reg;
        res_valid  = 1'b0;
        res        = '0;
        hdr_new    = (idx_reg < 4'd8) ? {hdr_reg[55:0], data_byte} : hdr_reg;
        fix_new    = (idx_reg < 4'd8) ? {fix_reg[55:0], data_byte} : fix_reg;
        rd_new     = (idx_reg < 4'd8) ? rd_reg : {rd_reg[7:0], data_byte};
        a_dec      = a_reg - 16'd1;
        rtype      = fix_new[63:48];
        ah_new     = {ah_reg[55:0], al_reg[63:56]};
        al_new     = {al_reg[55:0], data_byte};
        res.txid           = hdr_reg[63:48];
        res.flags          = hdr_reg[47:32];
        res.question_count = hdr_reg[31:16];
        res.answer_count   = hdr_reg[15:0];
        unique case (phase_reg)
            PH_HEADER:
            begin
                hdr_next = hdr_new;
                res.txid           = hdr_new[63:48];
                res.flags          = hdr_new[47:32];
                res.question_count = hdr_new[31:16];
                res.answer_count   = hdr_new[15:0];
                if (idx_reg >= HDR_LAST)
                begin
                    idx_next  = '0;
                    res_valid = 1'b1;
                    if (hdr_new[35:32] != 4'd0)
                    begin
                        res.kind   = KIND_RCODE;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        res.kind   = KIND_HEADER;
                        q_next     = hdr_new[31:16];
                        a_next     = hdr_new[15:0];
                        phase_next = (hdr_new[31:0] != 32'd0) ? PH_NAME : PH_DONE;
                    end
                end
                else
                    idx_next = idx_reg + 4'd1;
            end
            PH_NAME:
            begin
                if (data_byte == 8'd0)
                begin
                    idx_next   = '0;
                    phase_next = PH_FIXED;
                end
                else if ((data_byte & PTR_MASK) == PTR_MASK)
                    phase_next = PH_PTR;
                else
                begin
                    lab_next   = data_byte;
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                lab_next = lab_reg - 8'd1;
                if (lab_reg == 8'd1)
                    phase_next = PH_NAME;
            end
            PH_PTR:
            begin
                idx_next   = '0;
                phase_next = PH_FIXED;
            end
            PH_FIXED:
            begin
                if (q_reg != 16'd0)
                begin
                    if (idx_reg >= QFIXED_LAST)
                    begin
                        idx_next = '0;
                        q_next   = q_reg - 16'd1;
                        phase_next = (q_reg == 16'd1 && a_reg == 16'd0) ? PH_DONE : PH_NAME;
                    end
                    else
                        idx_next = idx_reg + 4'd1;
                end
                else
                begin
                    fix_next = fix_new;
                    rd_next  = rd_new;
                    if (idx_reg >= RFIXED_LAST)
                    begin
                        idx_next = '0;
                        if ((rtype == TYPE_A && rd_new == LEN_A) ||
                            (rtype == TYPE_AAAA && rd_new == LEN_AAAA))
                        begin
                            ah_next    = '0;
                            al_next    = '0;
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_OTHER;
                            res.record_type  = rtype;
                            res.time_to_live = fix_new[31:0];
                            res.data_length  = rd_new;
                            if (rd_new == 16'd0)
                            begin
                                a_next     = a_dec;
                                phase_next = (a_dec != 16'd0) ? PH_NAME : PH_DONE;
                            end
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                    else
                        idx_next = idx_reg + 4'd1;
                end
            end
            PH_SKIP:
            begin
                rd_next = rd_reg - 16'd1;
                if (rd_reg == 16'd1)
                begin
                    a_next     = a_dec;
                    phase_next = (a_dec != 16'd0) ? PH_NAME : PH_DONE;
                end
            end
            PH_ADDR:
            begin
                ah_next = ah_new;
                al_next = al_new;
                rd_next = rd_reg - 16'd1;
                if (rd_reg == 16'd1)
                begin
                    res_valid        = 1'b1;
                    res.record_type  = fix_reg[63:48];
                    res.time_to_live = fix_reg[31:0];
                    if (fix_reg[63:48] == TYPE_A)
                    begin
                        res.kind        = KIND_A;
                        res.data_length = LEN_A;
                        res.address_low = {32'd0, al_new[31:0]};
                    end
                    else
                    begin
                        res.kind         = KIND_AAAA;
                        res.data_length  = LEN_AAAA;
                        res.address_high = ah_new;
                        res.address_low  = al_new;
                    end
                    a_next     = a_dec;
                    phase_next = (a_dec != 16'd0) ? PH_NAME : PH_DONE;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // end of message: flag result or make one, then reset state
        if (last_byte)
        begin
            if (!res_valid)
            begin
                res_valid = 1'b1;
                res       = '0;
                if (phase_next == PH_HEADER)
                    res.kind = KIND_SHORT;
                else
                begin
                    res.kind           = KIND_END;
                    res.txid           = hdr_next[63:48];
                    res.flags          = hdr_next[47:32];
                    res.question_count = hdr_next[31:16];
                    res.answer_count   = hdr_next[15:0];
                end
            end
            res.message_end = 1'b1;
            phase_next = PH_HEADER;
            idx_next   = '0;
            hdr_next   = '0;
            q_next     = '0;
            a_next     = '0;
            lab_next   = '0;
            fix_next   = '0;
            rd_next    = '0;
            ah_next    = '0;
            al_next    = '0;
        end
        if (!in_valid)
            res_valid = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            idx_reg   <= '0;
            hdr_reg   <= '0;
            q_reg     <= '0;
            a_reg     <= '0;
            lab_reg   <= '0;
            fix_reg   <= '0;
            rd_reg    <= '0;
            ah_reg    <= '0;
            al_reg    <= '0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            hdr_reg   <= hdr_next;
            q_reg     <= q_next;
            a_reg     <= a_next;
            lab_reg   <= lab_next;
            fix_reg   <= fix_next;
            rd_reg    <= rd_next;
            ah_reg    <= ah_next;
            al_reg    <= al_next;
        end
    end

    // header phase index never passes the header length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (idx_reg <= HDR_LAST))
        else $error("header index out of range");

    // a final byte always returns the parser to the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && last_byte) |=> (phase_reg == PH_HEADER && idx_reg == 4'd0))
        else $error("parser not reset after final byte");

    // a final byte always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && last_byte) |-> res_valid)
        else $error("final byte without result");

endmodule

FILE: hdl/dnsrp_queue.sv
// result queue between parser and output port
// depends on dnsrp_pkg

module dnsrp_queue import dnsrp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    input  result_t wr_data,
    output logic    wr_ready,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t         mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign wr_ready = (cnt_reg != DEPTH[AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // fill count stays within depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH[AW:0])
        else $error("queue overflow");

    // count rises by one on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count mismatch");

    // an empty queue never pops
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule
